>>> sv/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and widths for the closest point on triangle block
// Word formats, datapath widths and the region codes.
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIFF_BITS  = COORD_BITS + 1;      // corner/point differences
    localparam int DOT_BITS   = 2 * DIFF_BITS + 2;   // d1..d6
    localparam int VOL_BITS   = 2 * DOT_BITS + 1;    // va, vb, vc
    localparam int NUM_BITS   = VOL_BITS + 2;        // projection factors, denominators
    localparam int PROD_BITS  = DIFF_BITS + NUM_BITS; // numerators
    localparam int QUOT_BITS  = COORD_BITS + 3;      // quotient magnitude, clamped
    localparam int SUM_BITS   = QUOT_BITS + 3;
    localparam int VOL_SEGS   = 2;                   // operand split of the d products
    localparam int NUM_SEGS   = 4;                   // factor split of the numerators
    localparam int MUL_LAT    = 2;
    localparam int DIV_LAT    = QUOT_BITS + 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic [2:0] {
        RGN_A    = 3'd0,
        RGN_B    = 3'd1,
        RGN_AB   = 3'd2,
        RGN_C    = 3'd3,
        RGN_AC   = 3'd4,
        RGN_BC   = 3'd5,
        RGN_FACE = 3'd6
    } region_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
        coord_t corner_a_x;
        coord_t corner_a_y;
        coord_t corner_a_z;
        coord_t corner_b_x;
        coord_t corner_b_y;
        coord_t corner_b_z;
        coord_t corner_c_x;
        coord_t corner_c_y;
        coord_t corner_c_z;
    } query_t;

    typedef struct packed {
        coord_t     closest_x;
        coord_t     closest_y;
        coord_t     closest_z;
        logic [2:0] region;
        logic       degenerate;
    } result_t;

    // triangle geometry carried alongside the dot products
    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] a;
        logic [2:0][COORD_BITS-1:0] b;
        logic [2:0][COORD_BITS-1:0] c;
        logic [2:0][DIFF_BITS-1:0]  ab;
        logic [2:0][DIFF_BITS-1:0]  ac;
        logic [2:0][DIFF_BITS-1:0]  bc;
    } geo_t;

    // per-word control carried alongside the projection datapath
    typedef struct packed {
        region_t                    region;
        logic                       vertex;
        logic                       zero_den;
        logic [2:0][COORD_BITS-1:0] base;
        logic [2:0][COORD_BITS-1:0] corner;
    } side_t;

endpackage

>>> sv/cpt_delay.sv
// ----------------------------------------------------------------------------
// cpt_delay: enabled register chain
// Keeps side data aligned with the arithmetic pipeline.
// ----------------------------------------------------------------------------
module cpt_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[DEPTH-1];

endmodule

>>> sv/cpt_mul.sv
// ----------------------------------------------------------------------------
// cpt_mul: two-stage signed multiplier
// Splits both operands into segments, registers the partial products,
// then sums them into the registered full product.
// ----------------------------------------------------------------------------
module cpt_mul #(
    parameter int AW = 25,
    parameter int BW = 25,
    parameter int NA = 1,
    parameter int NB = 1
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int SA = (AW + NA - 1) / NA;
    localparam int SB = (BW + NB - 1) / NB;
    localparam int AX = SA * NA;
    localparam int BX = SB * NB;
    localparam int PW = AW + BW;

    logic signed [AX-1:0]      a_ext;
    logic signed [BX-1:0]      b_ext;
    logic signed [SA:0]        a_pc [NA];
    logic signed [SB:0]        b_pc [NB];
    logic signed [SA+SB+1:0]   pp_reg [NA][NB];
    logic signed [PW-1:0]      acc;
    logic signed [PW-1:0]      p_reg;

    assign a_ext = AX'(a);
    assign b_ext = BX'(b);

    // low segments are unsigned, the top one carries the sign
    for (genvar i = 0; i < NA; i++)
    begin : g_apc
        if (i == NA - 1)
        begin : g_top
            assign a_pc[i] = $signed({a_ext[AX-1], a_ext[i*SA +: SA]});
        end
        else
        begin : g_low
            assign a_pc[i] = $signed({1'b0, a_ext[i*SA +: SA]});
        end
    end

    for (genvar j = 0; j < NB; j++)
    begin : g_bpc
        if (j == NB - 1)
        begin : g_top
            assign b_pc[j] = $signed({b_ext[BX-1], b_ext[j*SB +: SB]});
        end
        else
        begin : g_low
            assign b_pc[j] = $signed({1'b0, b_ext[j*SB +: SB]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= a_pc[i] * b_pc[j];
                end
            end
        end
    end

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                acc = acc + (PW'(pp_reg[i][j]) <<< (SA * i + SB * j));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= acc;
        end
    end

    assign p = p_reg;

endmodule

>>> sv/cpt_div.sv
// ----------------------------------------------------------------------------
// cpt_div: pipelined signed divider, truncating toward zero
// One restoring step per stage. Quotient magnitudes that do not fit in
// QB bits are clamped to all ones, which the caller saturates.
// ----------------------------------------------------------------------------
module cpt_div #(
    parameter int NUM_W = cpt_pkg::PROD_BITS,
    parameter int DEN_W = cpt_pkg::NUM_BITS,
    parameter int QB    = cpt_pkg::QUOT_BITS
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic signed [QB:0]      quot
);

    localparam int RW = ((NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB) + 1;

    logic [NUM_W-1:0]    nmag_reg;
    logic [DEN_W-1:0]    dmag_reg;
    logic                neg0_reg;
    logic [RW-1:0]       rem_reg [QB+1];
    logic [DEN_W-1:0]    dv_reg  [QB+1];
    logic [QB-1:0]       q_reg   [QB+1];
    logic                ovf_reg [QB+1];
    logic                neg_reg [QB+1];
    logic [QB-1:0]       mag;
    logic signed [QB:0]  mag_s;
    logic signed [QB:0]  quot_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag_reg <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            dmag_reg <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
            neg0_reg <= num[NUM_W-1] ^ den[DEN_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= RW'(nmag_reg);
            dv_reg[0]  <= dmag_reg;
            q_reg[0]   <= '0;
            ovf_reg[0] <= RW'(nmag_reg) >= (RW'(dmag_reg) << QB);
            neg_reg[0] <= neg0_reg;
        end
    end

    for (genvar s = 1; s <= QB; s++)
    begin : g_step
        localparam int BIT = QB - s;
        logic [RW:0]   trial;
        logic [QB-1:0] q_next;

        assign trial  = {1'b0, rem_reg[s-1]} - {1'b0, RW'(dv_reg[s-1]) << BIT};
        // bit BIT is still clear in the incoming quotient
        assign q_next = q_reg[s-1] | (QB'(!trial[RW]) << BIT);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]      <= trial[RW] ? rem_reg[s-1] : trial[RW-1:0];
                q_reg[s]        <= q_next;
                dv_reg[s]       <= dv_reg[s-1];
                ovf_reg[s]      <= ovf_reg[s-1];
                neg_reg[s]      <= neg_reg[s-1];
            end
        end
    end

    assign mag   = ovf_reg[QB] ? '1 : q_reg[QB];
    assign mag_s = $signed({1'b0, mag});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= neg_reg[QB] ? -mag_s : mag_s;
        end
    end

    assign quot = quot_reg;

endmodule

>>> sv/closest_point_on_triangle.sv
// ----------------------------------------------------------------------------
// closest_point_on_triangle: nearest point of a triangle to a query point
//
//   channel | signals                              | word
//   --------+--------------------------------------+-----------------------
//   query   | query_valid, query_stall, query      | point and corners A,B,C
//   result  | result_valid, result_stall, result   | point, region, degenerate
//
// Fixed pipeline of 40 stages: one word in per cycle unless a stalled result holds it.
// The depth is set by the 27-step divider plus the split multipliers.
// Reset clears only the valid bits; the datapath registers are not reset.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module closest_point_on_triangle (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              query_valid,
    output logic              query_stall,
    input  cpt_pkg::query_t   query,
    output logic              result_valid,
    input  logic              result_stall,
    output cpt_pkg::result_t  result
);

    localparam int CB = cpt_pkg::COORD_BITS;
    localparam int DW = cpt_pkg::DIFF_BITS;
    localparam int OW = cpt_pkg::DOT_BITS;
    localparam int VW = cpt_pkg::VOL_BITS;
    localparam int NW = cpt_pkg::NUM_BITS;
    localparam int PW = cpt_pkg::PROD_BITS;
    localparam int QB = cpt_pkg::QUOT_BITS;
    localparam int SW = cpt_pkg::SUM_BITS;
    localparam int ML = cpt_pkg::MUL_LAT;
    localparam int DL = cpt_pkg::DIV_LAT;
    localparam int L  = 8 + ML + DL;
    localparam longint CMAX = (longint'(1) <<< (CB - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;
    localparam logic signed [SW-1:0] SMAX = SW'(CMAX);
    localparam logic signed [SW-1:0] SMIN = SW'(CMIN);
    // operand pairs for d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
    localparam int MA [6] = '{0, 2, 4, 0, 2, 4};
    localparam int MB [6] = '{3, 1, 1, 5, 5, 3};

    logic            adv;
    logic [L-1:0]    vld_reg;

    assign adv          = !vld_reg[L-1] || !result_stall;
    assign query_stall  = !adv;
    assign result_valid = vld_reg[L-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[L-2:0], query_valid};
        end
    end

    // ---------------- stage 1: differences
    logic signed [CB-1:0] pt [3];
    logic signed [CB-1:0] ca [3];
    logic signed [CB-1:0] cb [3];
    logic signed [CB-1:0] cc [3];
    cpt_pkg::geo_t        geo_next;
    cpt_pkg::geo_t        geo1_reg;
    cpt_pkg::geo_t        geo6;
    logic signed [DW-1:0] ap_reg [3];
    logic signed [DW-1:0] bp_reg [3];
    logic signed [DW-1:0] cp_reg [3];

    always_comb
    begin
        pt[0] = query.point_x;
        pt[1] = query.point_y;
        pt[2] = query.point_z;
        ca[0] = query.corner_a_x;
        ca[1] = query.corner_a_y;
        ca[2] = query.corner_a_z;
        cb[0] = query.corner_b_x;
        cb[1] = query.corner_b_y;
        cb[2] = query.corner_b_z;
        cc[0] = query.corner_c_x;
        cc[1] = query.corner_c_y;
        cc[2] = query.corner_c_z;
        for (int k = 0; k < 3; k++)
        begin
            geo_next.a[k]  = ca[k];
            geo_next.b[k]  = cb[k];
            geo_next.c[k]  = cc[k];
            geo_next.ab[k] = DW'(cb[k]) - DW'(ca[k]);
            geo_next.ac[k] = DW'(cc[k]) - DW'(ca[k]);
            geo_next.bc[k] = DW'(cc[k]) - DW'(cb[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            geo1_reg <= geo_next;
            for (int k = 0; k < 3; k++)
            begin
                ap_reg[k] <= DW'(pt[k]) - DW'(ca[k]);
                bp_reg[k] <= DW'(pt[k]) - DW'(cb[k]);
                cp_reg[k] <= DW'(pt[k]) - DW'(cc[k]);
            end
        end
    end

    cpt_delay #(.W($bits(cpt_pkg::geo_t)), .DEPTH(5)) u_geo_dly (
        .clk (clk),
        .en  (adv),
        .d   (geo1_reg),
        .q   (geo6)
    );

    // ---------------- stage 2: coordinate products
    logic signed [DW-1:0]   lhs [6][3];
    logic signed [DW-1:0]   rhs [6][3];
    logic signed [2*DW-1:0] prod_reg [6][3];

    always_comb
    begin
        for (int m = 0; m < 6; m++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                lhs[m][k] = (m % 2 == 0) ? $signed(geo1_reg.ab[k]) : $signed(geo1_reg.ac[k]);
                if (m / 2 == 0)
                begin
                    rhs[m][k] = ap_reg[k];
                end
                else if (m / 2 == 1)
                begin
                    rhs[m][k] = bp_reg[k];
                end
                else
                begin
                    rhs[m][k] = cp_reg[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int m = 0; m < 6; m++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[m][k] <= lhs[m][k] * rhs[m][k];
                end
            end
        end
    end

    // ---------------- stage 3: d1..d6
    logic [5:0][OW-1:0] d_reg;
    logic [5:0][OW-1:0] d_dly;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int m = 0; m < 6; m++)
            begin
                d_reg[m] <= OW'(prod_reg[m][0]) + OW'(prod_reg[m][1]) + OW'(prod_reg[m][2]);
            end
        end
    end

    // ---------------- stages 4-5: cross products of d terms
    logic signed [2*OW-1:0] vprod [6];

    for (genvar g = 0; g < 6; g++)
    begin : g_vmul
        cpt_mul #(
            .AW (OW),
            .BW (OW),
            .NA (cpt_pkg::VOL_SEGS),
            .NB (cpt_pkg::VOL_SEGS)
        ) u_mul (
            .clk (clk),
            .en  (adv),
            .a   ($signed(d_reg[MA[g]])),
            .b   ($signed(d_reg[MB[g]])),
            .p   (vprod[g])
        );
    end

    cpt_delay #(.W(6 * OW), .DEPTH(ML)) u_d_dly (
        .clk (clk),
        .en  (adv),
        .d   (d_reg),
        .q   (d_dly)
    );

    // ---------------- stage 6: va, vb, vc and edge denominators
    logic signed [VW-1:0] va_reg;
    logic signed [VW-1:0] vb_reg;
    logic signed [VW-1:0] vc_reg;
    logic signed [NW-1:0] den2_reg;
    logic signed [NW-1:0] den4_reg;
    logic signed [NW-1:0] e43_reg;
    logic signed [NW-1:0] e56_reg;
    logic [5:0][OW-1:0]   dd_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vc_reg   <= VW'(vprod[0]) - VW'(vprod[1]);
            vb_reg   <= VW'(vprod[2]) - VW'(vprod[3]);
            va_reg   <= VW'(vprod[4]) - VW'(vprod[5]);
            den2_reg <= NW'($signed(d_dly[0])) - NW'($signed(d_dly[2]));
            den4_reg <= NW'($signed(d_dly[1])) - NW'($signed(d_dly[5]));
            e43_reg  <= NW'($signed(d_dly[3])) - NW'($signed(d_dly[2]));
            e56_reg  <= NW'($signed(d_dly[4])) - NW'($signed(d_dly[5]));
            dd_reg   <= d_dly;
        end
    end

    // ---------------- stage 7: region select
    logic signed [OW-1:0]  d1, d2, d3, d4, d5, d6;
    logic signed [NW-1:0]  den5;
    logic signed [NW-1:0]  dsum;
    logic signed [NW-1:0]  n1_next, n2_next, den_next;
    logic [2:0][DW-1:0]    dir1_next, dir2_next;
    cpt_pkg::side_t        side_next;
    logic signed [NW-1:0]  n1_reg, n2_reg, den7_reg, den9;
    logic [2:0][DW-1:0]    dir1_reg, dir2_reg;
    cpt_pkg::side_t        side7_reg;
    cpt_pkg::side_t        side_f;

    assign d1   = $signed(dd_reg[0]);
    assign d2   = $signed(dd_reg[1]);
    assign d3   = $signed(dd_reg[2]);
    assign d4   = $signed(dd_reg[3]);
    assign d5   = $signed(dd_reg[4]);
    assign d6   = $signed(dd_reg[5]);
    assign den5 = e43_reg + e56_reg;
    assign dsum = NW'(va_reg) + NW'(vb_reg) + NW'(vc_reg);

    always_comb
    begin
        n1_next          = '0;
        n2_next          = '0;
        den_next         = '0;
        dir1_next        = '0;
        dir2_next        = '0;
        side_next.region = cpt_pkg::RGN_FACE;
        side_next.vertex = 1'b0;
        side_next.base   = geo6.a;
        side_next.corner = geo6.a;
        priority if (d1 <= 0 && d2 <= 0)
        begin
            side_next.region = cpt_pkg::RGN_A;
            side_next.vertex = 1'b1;
        end
        else if (d3 >= 0 && d4 <= d3)
        begin
            side_next.region = cpt_pkg::RGN_B;
            side_next.vertex = 1'b1;
            side_next.corner = geo6.b;
        end
        else if (vc_reg <= 0 && d1 >= 0 && d3 <= 0)
        begin
            side_next.region = cpt_pkg::RGN_AB;
            n1_next          = NW'(d1);
            den_next         = den2_reg;
            dir1_next        = geo6.ab;
        end
        else if (d6 >= 0 && d5 <= d6)
        begin
            side_next.region = cpt_pkg::RGN_C;
            side_next.vertex = 1'b1;
            side_next.corner = geo6.c;
        end
        else if (vb_reg <= 0 && d2 >= 0 && d6 <= 0)
        begin
            side_next.region = cpt_pkg::RGN_AC;
            n1_next          = NW'(d2);
            den_next         = den4_reg;
            dir1_next        = geo6.ac;
        end
        else if (va_reg <= 0 && e43_reg >= 0 && e56_reg >= 0)
        begin
            side_next.region = cpt_pkg::RGN_BC;
            n1_next          = e43_reg;
            den_next         = den5;
            dir1_next        = geo6.bc;
            side_next.base   = geo6.b;
        end
        else
        begin
            n1_next   = NW'(vb_reg);
            n2_next   = NW'(vc_reg);
            den_next  = dsum;
            dir1_next = geo6.ab;
            dir2_next = geo6.ac;
        end
        // corner stays A for projections: it is the fallback on a zero denominator
        side_next.zero_den = (den_next == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n1_reg    <= n1_next;
            n2_reg    <= n2_next;
            den7_reg  <= den_next;
            dir1_reg  <= dir1_next;
            dir2_reg  <= dir2_next;
            side7_reg <= side_next;
        end
    end

    // ---------------- stages 8-9: numerators, one per coordinate and term, then the dividers
    logic signed [PW-1:0] num [6];
    logic signed [QB:0]   quot [6];

    for (genvar g = 0; g < 6; g++)
    begin : g_nmul
        logic signed [DW-1:0] dir_g;
        logic signed [NW-1:0] fac_g;

        if (g < 3)
        begin : g_t1
            assign dir_g = $signed(dir1_reg[g]);
            assign fac_g = n1_reg;
        end
        else
        begin : g_t2
            assign dir_g = $signed(dir2_reg[g-3]);
            assign fac_g = n2_reg;
        end

        cpt_mul #(
            .AW (DW),
            .BW (NW),
            .NA (1),
            .NB (cpt_pkg::NUM_SEGS)
        ) u_mul (
            .clk (clk),
            .en  (adv),
            .a   (dir_g),
            .b   (fac_g),
            .p   (num[g])
        );

        cpt_div #(
            .NUM_W (PW),
            .DEN_W (NW),
            .QB    (QB)
        ) u_div (
            .clk  (clk),
            .en   (adv),
            .num  (num[g]),
            .den  (den9),
            .quot (quot[g])
        );
    end

    cpt_delay #(.W(NW), .DEPTH(ML)) u_den_dly (
        .clk (clk),
        .en  (adv),
        .d   (den7_reg),
        .q   (den9)
    );

    cpt_delay #(.W($bits(cpt_pkg::side_t)), .DEPTH(ML + DL)) u_side_dly (
        .clk (clk),
        .en  (adv),
        .d   (side7_reg),
        .q   (side_f)
    );

    // ---------------- last stage: sum, saturate, pick
    logic signed [SW-1:0] sum [3];
    logic [2:0][CB-1:0]   sat;
    logic [2:0][CB-1:0]   pick;
    cpt_pkg::result_t     result_next;
    cpt_pkg::result_t     result_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum[k] = SW'($signed(side_f.base[k])) + SW'(quot[k]) + SW'(quot[k+3]);
            if (sum[k] > SMAX)
            begin
                sat[k] = CB'(CMAX);
            end
            else if (sum[k] < SMIN)
            begin
                sat[k] = CB'(CMIN);
            end
            else
            begin
                sat[k] = sum[k][CB-1:0];
            end
        end
        pick = (side_f.vertex || side_f.zero_den) ? side_f.corner : sat;
        result_next.closest_x  = pick[0];
        result_next.closest_y  = pick[1];
        result_next.closest_z  = pick[2];
        result_next.region     = side_f.region;
        result_next.degenerate = !side_f.vertex && side_f.zero_den;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for closest_point_on_triangle
// Drives query words with random gaps, stalls the result channel at random,
// and compares every result word with an exact wide-integer prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [255:0] wide_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;

    logic             clk;
    logic             rst_n;
    logic             query_valid;
    logic             query_stall;
    cpt_pkg::query_t  query;
    logic             result_valid;
    logic             result_stall;
    cpt_pkg::result_t result;

    cpt_pkg::result_t pending_results[$];
    int      error_count;
    int      idle_cycles;
    int      stall_left;
    bit      calm;
    bit      result_taken;

    closest_point_on_triangle i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_stall  (query_stall),
        .query        (query),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic cpt_pkg::coord_t clamp_coord(wide_t v);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (cpt_pkg::COORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v >= hi)
            return cpt_pkg::coord_t'(hi);
        if (v <= lo)
            return cpt_pkg::coord_t'(lo);
        return cpt_pkg::coord_t'(v);
    endfunction

    function automatic wide_t dot(wide_t x[3], wide_t y[3]);
        return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
    endfunction

    function automatic cpt_pkg::result_t nearest_point(cpt_pkg::query_t q);
        wide_t   p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
        wide_t   d1, d2, d3, d4, d5, d6, va, vb, vc, e43, e56, den, num;
        wide_t   base[3], dir[3];
        cpt_pkg::coord_t  r[3];
        cpt_pkg::region_t rgn;
        bit      bad;
        bit      vert;
        cpt_pkg::result_t res;
        p[0] = wide_t'(q.point_x);    p[1] = wide_t'(q.point_y);
        p[2] = wide_t'(q.point_z);
        a[0] = wide_t'(q.corner_a_x); a[1] = wide_t'(q.corner_a_y);
        a[2] = wide_t'(q.corner_a_z);
        b[0] = wide_t'(q.corner_b_x); b[1] = wide_t'(q.corner_b_y);
        b[2] = wide_t'(q.corner_b_z);
        c[0] = wide_t'(q.corner_c_x); c[1] = wide_t'(q.corner_c_y);
        c[2] = wide_t'(q.corner_c_z);
        for (int k = 0; k < 3; k++)
        begin
            ab[k] = b[k] - a[k];
            ac[k] = c[k] - a[k];
            bc[k] = c[k] - b[k];
            ap[k] = p[k] - a[k];
            bp[k] = p[k] - b[k];
            cp[k] = p[k] - c[k];
        end
        d1 = dot(ab, ap); d2 = dot(ac, ap);
        d3 = dot(ab, bp); d4 = dot(ac, bp);
        d5 = dot(ab, cp); d6 = dot(ac, cp);
        vc = d1 * d4 - d3 * d2;
        vb = d5 * d2 - d1 * d6;
        va = d3 * d6 - d5 * d4;
        e43 = d4 - d3;
        e56 = d5 - d6;
        bad  = 1'b0;
        vert = 1'b0;
        num  = '0;
        den  = wide_t'(1);
        base = a;
        dir  = ab;
        if (d1 <= 0 && d2 <= 0)
        begin
            rgn = cpt_pkg::RGN_A; vert = 1'b1;
            for (int k = 0; k < 3; k++) r[k] = cpt_pkg::coord_t'(a[k]);
        end
        else if (d3 >= 0 && d4 <= d3)
        begin
            rgn = cpt_pkg::RGN_B; vert = 1'b1;
            for (int k = 0; k < 3; k++) r[k] = cpt_pkg::coord_t'(b[k]);
        end
        else if (vc <= 0 && d1 >= 0 && d3 <= 0)
        begin
            rgn = cpt_pkg::RGN_AB; num = d1; den = d1 - d3;
        end
        else if (d6 >= 0 && d5 <= d6)
        begin
            rgn = cpt_pkg::RGN_C; vert = 1'b1;
            for (int k = 0; k < 3; k++) r[k] = cpt_pkg::coord_t'(c[k]);
        end
        else if (vb <= 0 && d2 >= 0 && d6 <= 0)
        begin
            rgn = cpt_pkg::RGN_AC; num = d2; den = d2 - d6; dir = ac;
        end
        else if (va <= 0 && e43 >= 0 && e56 >= 0)
        begin
            rgn = cpt_pkg::RGN_BC; num = e43; den = e43 + e56; base = b; dir = bc;
        end
        else
        begin
            rgn = cpt_pkg::RGN_FACE;
            den = va + vb + vc;
        end
        if (!vert)
        begin
            if (den == 0)
            begin
                bad = 1'b1;
                for (int k = 0; k < 3; k++) r[k] = cpt_pkg::coord_t'(a[k]);
            end
            else if (rgn == cpt_pkg::RGN_FACE)
            begin
                for (int k = 0; k < 3; k++)
                    r[k] = clamp_coord(a[k] + (ab[k] * vb) / den + (ac[k] * vc) / den);
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                    r[k] = clamp_coord(base[k] + (dir[k] * num) / den);
            end
        end
        res.closest_x  = r[0];
        res.closest_y  = r[1];
        res.closest_z  = r[2];
        res.region     = rgn;
        res.degenerate = bad;
        return res;
    endfunction

    function automatic cpt_pkg::query_t make_query(
            cpt_pkg::coord_t px, cpt_pkg::coord_t py, cpt_pkg::coord_t pz,
            cpt_pkg::coord_t ax, cpt_pkg::coord_t ay, cpt_pkg::coord_t az,
            cpt_pkg::coord_t bx, cpt_pkg::coord_t by, cpt_pkg::coord_t bz,
            cpt_pkg::coord_t cx, cpt_pkg::coord_t cy, cpt_pkg::coord_t cz);
        cpt_pkg::query_t q;
        q.point_x = px;    q.point_y = py;    q.point_z = pz;
        q.corner_a_x = ax; q.corner_a_y = ay; q.corner_a_z = az;
        q.corner_b_x = bx; q.corner_b_y = by; q.corner_b_z = bz;
        q.corner_c_x = cx; q.corner_c_y = cy; q.corner_c_z = cz;
        return q;
    endfunction

    function automatic cpt_pkg::coord_t rand_full();
        return cpt_pkg::coord_t'($urandom);
    endfunction

    function automatic cpt_pkg::coord_t rand_near(cpt_pkg::coord_t center, int span);
        return clamp_coord(wide_t'(center) + wide_t'($urandom_range(0, 2 * span))
                           - wide_t'(span));
    endfunction

    function automatic cpt_pkg::coord_t rand_edge_value();
        case ($urandom_range(0, 5))
            0: return cpt_pkg::coord_t'(24'h7fffff);
            1: return cpt_pkg::coord_t'(24'h800000);
            2: return cpt_pkg::coord_t'(0);
            3: return cpt_pkg::coord_t'(1);
            4: return cpt_pkg::coord_t'(-1);
            default: return rand_full();
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR: %s got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // at a gap of zero the payload changes with valid held high
    task automatic send_word(cpt_pkg::query_t q);
        int gap;
        bit st;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            query_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        query       <= q;
        query_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            st = query_stall;
            @(posedge clk);
        end
        while (st);
        pending_results.push_back(nearest_point(q));
    endtask

    // result words: acceptance seen at the negedge before the capturing edge
    always @(negedge clk)
    begin
        result_taken = 1'b0;
        if (rst_n)
        begin
            if ((result_valid && !result_stall) || (query_valid && !query_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (result_valid && !result_stall)
            begin
                result_taken = 1'b1;
                if (pending_results.size() == 0)
                begin
                    $display("ERROR: result word with nothing pending");
                    error_count++;
                end
                else
                begin
                    cpt_pkg::result_t want;
                    want = pending_results.pop_front();
                    if (result.closest_x !== want.closest_x)
                        report_mismatch("closest_x", result.closest_x, want.closest_x);
                    if (result.closest_y !== want.closest_y)
                        report_mismatch("closest_y", result.closest_y, want.closest_y);
                    if (result.closest_z !== want.closest_z)
                        report_mismatch("closest_z", result.closest_z, want.closest_z);
                    if (result.region !== want.region)
                        report_mismatch("region", result.region, want.region);
                    if (result.degenerate !== want.degenerate)
                        report_mismatch("degenerate", result.degenerate, want.degenerate);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("closest_point_on_triangle: mismatch");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (result_taken)
            stall_left = calm ? 0 : $urandom_range(0, 13);
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else
            result_stall <= 1'b0;
    end

    task automatic test_corner_values();
        cpt_pkg::coord_t mx;
        cpt_pkg::coord_t mn;
        mx = cpt_pkg::coord_t'(24'h7fffff);
        mn = cpt_pkg::coord_t'(24'h800000);
        send_word(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_query(mx, mx, mx, mn, mn, mn, mx, mn, mn, mn, mx, mn));
        send_word(make_query(mn, mn, mn, mx, mx, mx, mn, mx, mx, mx, mn, mx));
        send_word(make_query(mx, mn, mx, mn, mx, mn, mx, mx, mn, mn, mn, mx));
        send_word(make_query(mn, mx, 0, mx, mn, 0, mn, mn, 0, mx, mx, 0));
        send_word(make_query(-1, -1, -1, 1, 1, 1, mx, 0, 0, 0, mx, 0));
    endtask

    task automatic test_regions();
        // triangle A(0,0,0) B(4096,0,0) C(0,4096,0), probes in every region
        send_word(make_query(-500, -500, 77, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        send_word(make_query(5000, -300, -9, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        send_word(make_query(2000, -800, 40, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        send_word(make_query(-200, 5000, 3, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        send_word(make_query(-700, 1500, -60, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        send_word(make_query(3000, 3000, 11, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        send_word(make_query(1000, 1000, 900, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        send_word(make_query(1365, 1365, -5, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
    endtask

    task automatic test_degenerate();
        // A = B with P along AC: zero edge AB denominator
        send_word(make_query(100, 900, 0, 50, 50, 50, 50, 50, 50, 50, 4000, 50));
        // A = C with P beyond A: lands in vertex region A
        send_word(make_query(-900, 100, 0, 0, 0, 0, 3000, 0, 0, 0, 0, 0));
        // B = C with P beyond them: lands in vertex region B
        send_word(make_query(3000, 10, 0, 0, 0, 0, 2000, 0, 0, 2000, 0, 0));
        // collinear corners, point off the line
        send_word(make_query(1000, 700, 0, 0, 0, 0, 1000, 0, 0, 3000, 0, 0));
        send_word(make_query(1500, -400, 0, 0, 0, 0, 3000, 0, 0, 1000, 0, 0));
        // all corners equal
        send_word(make_query(8, 9, 10, 7, 7, 7, 7, 7, 7, 7, 7, 7));
    endtask

    task automatic test_random(int count);
        cpt_pkg::query_t q;
        cpt_pkg::coord_t ctr[3];
        int     span;
        int     kind;
        for (int n = 0; n < count; n++)
        begin
            if (n % 150 == 0)
                calm = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                span = (kind < 30) ? 4000 : 2000000;
                for (int k = 0; k < 3; k++) ctr[k] = rand_full();
                q = make_query(rand_near(ctr[0], span), rand_near(ctr[1], span),
                               rand_near(ctr[2], span), rand_near(ctr[0], span),
                               rand_near(ctr[1], span), rand_near(ctr[2], span),
                               rand_near(ctr[0], span), rand_near(ctr[1], span),
                               rand_near(ctr[2], span), rand_near(ctr[0], span),
                               rand_near(ctr[1], span), rand_near(ctr[2], span));
            end
            else if (kind < 72)
                q = make_query(rand_full(), rand_full(), rand_full(), rand_full(),
                               rand_full(), rand_full(), rand_full(), rand_full(),
                               rand_full(), rand_full(), rand_full(), rand_full());
            else if (kind < 87)
            begin
                // collapsed shapes: shared corners or C on line AB
                q = make_query(rand_near(0, 3000), rand_near(0, 3000), rand_near(0, 3000),
                               rand_near(0, 2000), rand_near(0, 2000), rand_near(0, 2000),
                               rand_near(0, 2000), rand_near(0, 2000), rand_near(0, 2000),
                               0, 0, 0);
                case ($urandom_range(0, 3))
                    0:
                    begin
                        q.corner_b_x = q.corner_a_x; q.corner_b_y = q.corner_a_y;
                        q.corner_b_z = q.corner_a_z;
                        q.corner_c_x = rand_near(0, 2000); q.corner_c_y = rand_near(0, 2000);
                        q.corner_c_z = rand_near(0, 2000);
                    end
                    1:
                    begin
                        q.corner_c_x = q.corner_b_x; q.corner_c_y = q.corner_b_y;
                        q.corner_c_z = q.corner_b_z;
                    end
                    2:
                    begin
                        q.corner_c_x = q.corner_a_x; q.corner_c_y = q.corner_a_y;
                        q.corner_c_z = q.corner_a_z;
                    end
                    default:
                    begin
                        span = $urandom_range(0, 4) - 2;
                        q.corner_c_x = cpt_pkg::coord_t'(q.corner_a_x
                                       + span * (q.corner_b_x - q.corner_a_x));
                        q.corner_c_y = cpt_pkg::coord_t'(q.corner_a_y
                                       + span * (q.corner_b_y - q.corner_a_y));
                        q.corner_c_z = cpt_pkg::coord_t'(q.corner_a_z
                                       + span * (q.corner_b_z - q.corner_a_z));
                    end
                endcase
            end
            else
                q = make_query(rand_edge_value(), rand_edge_value(), rand_edge_value(),
                               rand_edge_value(), rand_edge_value(), rand_edge_value(),
                               rand_edge_value(), rand_edge_value(), rand_edge_value(),
                               rand_edge_value(), rand_edge_value(), rand_edge_value());
            send_word(q);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        query_valid  = 1'b0;
        query        = '0;
        result_stall = 1'b0;
        error_count  = 0;
        idle_cycles  = 0;
        stall_left   = 0;
        calm         = 1'b0;
        result_taken = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_values();
        test_regions();
        test_degenerate();
        test_random(1050);
        query_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("closest_point_on_triangle: match");
        else
            $display("closest_point_on_triangle: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
sv/cpt_pkg.sv
sv/cpt_delay.sv
sv/cpt_mul.sv
sv/cpt_div.sv
sv/closest_point_on_triangle.sv
bench/tb_top.sv
